[rtl/core/npgs_pkg.sv]
// Shared types for the nearest previous greater/smaller block.
`timescale 1ns / 1ps
package npgs_pkg;

   // Compare mode register codes
   typedef enum logic {
      MODE_GREATER = 1'b0,
      MODE_SMALLER = 1'b1
   } cmp_mode_type;

endpackage

[rtl/core/nearest_previous_greater_or_smaller.sv]
// Top level: monotonic stack finding the nearest previous greater/smaller value.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_ready  | req_sample, req_start_req
//   rsp     | out       | rsp_valid / rsp_ready  | rsp_neighbour, rsp_found, rsp_overflow
//   csr     | in        | csr_valid / csr_ready  | csr_compare_mode
//
// An item is accepted in ST_IDLE and then tested in ST_TEST: the sequencer runs the
// shared compare unit once per cycle against the stack top read from the memory port.
// The stack is a ring buffer, so a full-stack push just overwrites the oldest slot.
// Reset empties the stack at once; no clearing pass is needed.
// A result waits in its output register; the block holds in the compare state
// only when a new result is ready while the previous one is still not taken.
`timescale 1ns / 1ps
module nearest_previous_greater_or_smaller
   import npgs_pkg::*;
#(
   parameter int STACK_DEPTH = 1024,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [VALUE_WIDTH-1:0] req_sample,
   input  logic                   req_start_req,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [VALUE_WIDTH-1:0] rsp_neighbour,
   output logic                   rsp_found,
   output logic                   rsp_overflow,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_compare_mode
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam logic [AW-1:0] LAST_IDX = AW'(STACK_DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);

   typedef enum logic {
      ST_IDLE,
      ST_TEST
   } state_type;

   state_type              state_ff, state_in;
   cmp_mode_type           mode_ff, mode_in;
   logic [AW-1:0]          wp_ff, wp_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] sample_ff, sample_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] nbr_ff, nbr_in;
   logic                   found_ff, found_in;
   logic                   ovf_ff, ovf_in;

   logic                   wr_en;
   logic [AW-1:0]          rd_addr;
   logic [VALUE_WIDTH-1:0] top_value;
   logic                   cmp_pop;
   logic                   do_pop;
   logic                   out_free;

   function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
      ptr_dec = (p == '0) ? LAST_IDX : p - AW'(1);
   endfunction

   function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
      ptr_inc = (p == LAST_IDX) ? '0 : p + AW'(1);
   endfunction

   npgs_stack_mem #(
      .STACK_DEPTH (STACK_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH),
      .AW          (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (sample_ff),
      .rd_addr (rd_addr),
      .rd_data (top_value)
   );

   npgs_cmp #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_cmp (
      .mode      (mode_ff),
      .top_value (top_value),
      .new_value (sample_ff),
      .pop       (cmp_pop)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign do_pop    = (cnt_ff != '0) && cmp_pop;
   // always read the top of the stack as it will stand next cycle
   assign rd_addr   = ptr_dec(wp_in);

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      wp_in        = wp_ff;
      cnt_in       = cnt_ff;
      sample_in    = sample_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      nbr_in       = nbr_ff;
      found_in     = found_ff;
      ovf_in       = ovf_ff;
      wr_en        = 1'b0;

      if (csr_valid) begin
         mode_in = cmp_mode_type'(csr_compare_mode);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sample_in = req_sample;
               if (req_start_req) begin
                  cnt_in = '0;
               end
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            if (do_pop) begin
               wp_in  = ptr_dec(wp_ff);
               cnt_in = cnt_ff - CW'(1);
            end else if (out_free) begin
               // report the top, then push the sample
               rsp_valid_in = 1'b1;
               found_in     = (cnt_ff != '0);
               nbr_in       = (cnt_ff != '0) ? top_value : '1;
               ovf_in       = (cnt_ff == FULL_CNT);
               wr_en        = 1'b1;
               wp_in        = ptr_inc(wp_ff);
               if (cnt_ff != FULL_CNT) begin
                  cnt_in = cnt_ff + CW'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_GREATER;
         wp_ff        <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         wp_ff        <= wp_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff <= sample_in;
      nbr_ff    <= nbr_in;
      found_ff  <= found_in;
      ovf_ff    <= ovf_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_neighbour = nbr_ff;
   assign rsp_found     = found_ff;
   assign rsp_overflow  = ovf_ff;

   // fill count never exceeds the stack size
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FULL_CNT)
      else $error("stack count out of range");

   // a dropped bottom entry means the stack held a qualifying top
   a_ovf_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_overflow |-> rsp_found)
      else $error("overflow without a neighbour");

   // no neighbour reports all ones
   a_none_ones: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found |-> (rsp_neighbour == '1))
      else $error("missing neighbour not all ones");

   // an empty stack finishes the item as soon as the output is free
   a_empty_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TEST) && (cnt_ff == '0) && out_free |=> (state_ff == ST_IDLE))
      else $error("empty stack did not finish the item");

endmodule

[rtl/core/npgs_stack_mem.sv]
// Stack storage: one write port, one registered read port.
`timescale 1ns / 1ps
module npgs_stack_mem #(
   parameter int STACK_DEPTH = 1024,
   parameter int VALUE_WIDTH = 32,
   parameter int AW          = $clog2(STACK_DEPTH)
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [AW-1:0]          wr_addr,
   input  logic [VALUE_WIDTH-1:0] wr_data,
   input  logic [AW-1:0]          rd_addr,
   output logic [VALUE_WIDTH-1:0] rd_data
);

   logic [VALUE_WIDTH-1:0] mem [STACK_DEPTH];
   logic [VALUE_WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, old data on collision
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/npgs_cmp.sv]
// Shared signed compare unit: flags a stack top that fails the test.
`timescale 1ns / 1ps
module npgs_cmp
   import npgs_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  cmp_mode_type           mode,
   input  logic [VALUE_WIDTH-1:0] top_value,
   input  logic [VALUE_WIDTH-1:0] new_value,
   output logic                   pop
);

   logic signed [VALUE_WIDTH-1:0] top_s;
   logic signed [VALUE_WIDTH-1:0] new_s;

   assign top_s = $signed(top_value);
   assign new_s = $signed(new_value);

   // equal values never qualify, so they are popped in both modes
   always_comb begin
      unique case (mode)
         MODE_GREATER: pop = (top_s <= new_s);
         MODE_SMALLER: pop = (top_s >= new_s);
         default:      pop = 1'b0;
      endcase
   end

endmodule
